[src/msb_pkg.sv]
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants for the multiset bag table core.
// ----------------------------------------------------------------------------
package msb_pkg;

  // Table geometry.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_ERASE1  = 3'd1,
    OP_ERASEA  = 3'd2,
    OP_COUNT   = 3'd3,
    OP_SORT    = 3'd4,
    OP_DEDUP   = 3'd5,
    OP_READ_AT = 3'd6
  } op_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_RDAT,
    S_RDAT2,
    S_RD,
    S_CMP,
    S_LASTRD,
    S_LASTWR,
    S_SORT_TOP,
    S_SORT_LI,
    S_SORT_RJ,
    S_SORT_CJ,
    S_SORT_W1,
    S_SORT_W2,
    S_DD_TOP,
    S_DD_KEY
  } state_t;

  // Read address source.
  typedef enum logic [1:0] {
    RD_J,
    RD_I,
    RD_CNT,
    RD_IDX
  } rd_src_t;

  // Write address and data source.
  typedef enum logic [1:0] {
    WR_INS,
    WR_J_RD,
    WR_MI_VI,
    WR_I_MV
  } wr_src_t;

  // Commands from controller to datapath.
  typedef struct packed {
    rd_src_t rd_src;
    logic    wr_en;
    wr_src_t wr_src;
    logic    load;
    logic    key_rd;
    logic    j_inc;
    logic    j_clr;
    logic    n_count;
    logic    n_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    found_set;
    logic    i_inc;
    logic    sort_latch;
    logic    sort_upd;
    logic    fin;
    logic    fin_ok;
    logic    fin_mc;
    logic    fin_rv;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic full;
    logic j_end;
    logic i_lt;
    logic sort_more;
    logic idx_ok;
    logic match;
    logic n_gt1;
    logic swap;
    logic found;
  } sts_t;

endpackage

[src/msb_ram.sv]
// ----------------------------------------------------------------------------
// msb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/msb_datapath.sv]
// ----------------------------------------------------------------------------
// msb_datapath
// Entry store, fill count, scan cursors and result registers.
// ----------------------------------------------------------------------------
module msb_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  msb_pkg::cmd_t               cmd,
  output msb_pkg::sts_t               sts,
  input  logic signed [31:0]          value,
  input  logic [5:0]                  index,
  output logic                        done,
  output logic                        ok,
  output logic [6:0]                  match_count,
  output logic signed [31:0]          read_value,
  output logic [6:0]                  fill_level
);

  logic [msb_pkg::CNT_W-1:0]  count;
  logic [msb_pkg::CNT_W-1:0]  i;
  logic [msb_pkg::CNT_W-1:0]  j;
  logic [msb_pkg::CNT_W-1:0]  n;
  logic [msb_pkg::ADDR_W-1:0] mi;
  logic [msb_pkg::ADDR_W-1:0] idx_q;
  logic [msb_pkg::DATA_W-1:0] key;
  logic [msb_pkg::DATA_W-1:0] mv;
  logic [msb_pkg::DATA_W-1:0] vi;
  logic                       found;
  logic [msb_pkg::ADDR_W-1:0] rd_addr;
  logic [msb_pkg::ADDR_W-1:0] wr_addr;
  logic [msb_pkg::DATA_W-1:0] wr_data;
  logic [msb_pkg::DATA_W-1:0] rdata;
  logic [msb_pkg::CNT_W-1:0]  i_plus;
  logic                       less;

  assign i_plus = i + msb_pkg::CNT_W'(1);
  assign less   = $signed(rdata) < $signed(mv);

  // Address and data selection for the entry store.
  always_comb begin
    case (cmd.rd_src)
      msb_pkg::RD_J:   rd_addr = j[msb_pkg::ADDR_W-1:0];
      msb_pkg::RD_I:   rd_addr = i[msb_pkg::ADDR_W-1:0];
      msb_pkg::RD_CNT: rd_addr = count[msb_pkg::ADDR_W-1:0];
      msb_pkg::RD_IDX: rd_addr = idx_q;
      default:         rd_addr = '0;
    endcase
    case (cmd.wr_src)
      msb_pkg::WR_INS: begin
        wr_addr = count[msb_pkg::ADDR_W-1:0];
        wr_data = key;
      end
      msb_pkg::WR_J_RD: begin
        wr_addr = j[msb_pkg::ADDR_W-1:0];
        wr_data = rdata;
      end
      msb_pkg::WR_MI_VI: begin
        wr_addr = mi;
        wr_data = vi;
      end
      msb_pkg::WR_I_MV: begin
        wr_addr = i[msb_pkg::ADDR_W-1:0];
        wr_data = mv;
      end
      default: begin
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  msb_ram #(
    .WIDTH (msb_pkg::DATA_W),
    .DEPTH (msb_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  // Status flags for the controller.
  always_comb begin
    sts.full      = count == msb_pkg::CNT_W'(msb_pkg::CAPACITY);
    sts.j_end     = j >= count;
    sts.i_lt      = i < count;
    sts.sort_more = i_plus < count;
    sts.idx_ok    = {1'b0, idx_q} < count;
    sts.match     = rdata == key;
    sts.n_gt1     = n > msb_pkg::CNT_W'(1);
    sts.swap      = mi != i[msb_pkg::ADDR_W-1:0];
    sts.found     = found;
  end

  // Control registers: fill count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cmd.cnt_inc) begin
        count <= count + msb_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - msb_pkg::CNT_W'(1);
      end
    end
  end

  // Cursors, key and sort working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key   <= value;
      idx_q <= index;
      i     <= '0;
      j     <= '0;
      n     <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.key_rd) begin
        key <= rdata;
        n   <= '0;
      end else if (cmd.n_count && sts.match) begin
        n <= n + msb_pkg::CNT_W'(1);
      end else if (cmd.n_dec) begin
        n <= n - msb_pkg::CNT_W'(1);
      end
      if (cmd.found_set) begin
        found <= 1'b1;
      end
      if (cmd.i_inc) begin
        i <= i_plus;
      end
      if (cmd.sort_latch) begin
        j  <= i_plus;
        mi <= i[msb_pkg::ADDR_W-1:0];
        mv <= rdata;
        vi <= rdata;
      end else if (cmd.j_clr) begin
        j <= '0;
      end else if (cmd.j_inc) begin
        j <= j + msb_pkg::CNT_W'(1);
      end
      if (cmd.sort_upd && less) begin
        mi <= j[msb_pkg::ADDR_W-1:0];
        mv <= rdata;
      end
    end
  end

  // Result registers, loaded as the operation finishes.
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      ok          <= cmd.fin_ok;
      match_count <= cmd.fin_mc ? n : 7'd0;
      read_value  <= cmd.fin_rv ? rdata : 32'sd0;
    end
  end

  assign fill_level = count;

endmodule

[src/msb_ctrl.sv]
// ----------------------------------------------------------------------------
// msb_ctrl
// Sequencer that walks each operation through the datapath.
// ----------------------------------------------------------------------------
module msb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    op,
  output logic          busy,
  input  msb_pkg::sts_t sts,
  output msb_pkg::cmd_t cmd
);

  msb_pkg::state_t state, state_next;
  msb_pkg::op_t    op_q;
  logic            dd_cnt, dd_cnt_next;

  // State register and latched operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= msb_pkg::S_IDLE;
      dd_cnt <= 1'b0;
    end else begin
      state  <= state_next;
      dd_cnt <= dd_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == msb_pkg::S_IDLE && start) begin
      op_q <= msb_pkg::op_t'(op);
    end
  end

  assign busy = state != msb_pkg::S_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    dd_cnt_next = dd_cnt;
    cmd         = '0;
    case (state)
      msb_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (op)
            msb_pkg::OP_INSERT:  state_next = msb_pkg::S_INS;
            msb_pkg::OP_ERASE1,
            msb_pkg::OP_ERASEA,
            msb_pkg::OP_COUNT:   state_next = msb_pkg::S_RD;
            msb_pkg::OP_SORT:    state_next = msb_pkg::S_SORT_TOP;
            msb_pkg::OP_DEDUP:   state_next = msb_pkg::S_DD_TOP;
            msb_pkg::OP_READ_AT: state_next = msb_pkg::S_RDAT;
            default: begin
              cmd.fin = 1'b1;
            end
          endcase
        end
      end
      msb_pkg::S_INS: begin
        if (!sts.full) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_src  = msb_pkg::WR_INS;
          cmd.cnt_inc = 1'b1;
          cmd.fin_ok  = 1'b1;
        end
        cmd.fin    = 1'b1;
        state_next = msb_pkg::S_IDLE;
      end
      msb_pkg::S_RDAT: begin
        if (sts.idx_ok) begin
          cmd.rd_src = msb_pkg::RD_IDX;
          state_next = msb_pkg::S_RDAT2;
        end else begin
          cmd.fin    = 1'b1;
          state_next = msb_pkg::S_IDLE;
        end
      end
      msb_pkg::S_RDAT2: begin
        cmd.fin    = 1'b1;
        cmd.fin_ok = 1'b1;
        cmd.fin_rv = 1'b1;
        state_next = msb_pkg::S_IDLE;
      end
      // Scan: issue a read at the cursor; at the end, finish the operation or the dedup pass.
      msb_pkg::S_RD: begin
        if (sts.j_end) begin
          case (op_q)
            msb_pkg::OP_COUNT: begin
              cmd.fin    = 1'b1;
              cmd.fin_ok = 1'b1;
              cmd.fin_mc = 1'b1;
              state_next = msb_pkg::S_IDLE;
            end
            msb_pkg::OP_ERASEA: begin
              cmd.fin    = 1'b1;
              cmd.fin_ok = sts.found;
              state_next = msb_pkg::S_IDLE;
            end
            msb_pkg::OP_DEDUP: begin
              state_next = msb_pkg::S_LASTWR;
            end
            default: begin
              cmd.fin    = 1'b1;
              state_next = msb_pkg::S_IDLE;
            end
          endcase
          if (op_q == msb_pkg::OP_DEDUP) begin
            // End of a dedup pass: decide whether another erase follows.
            if (sts.n_gt1) begin
              cmd.n_dec   = 1'b1;
              cmd.j_clr   = 1'b1;
              dd_cnt_next = 1'b0;
              state_next  = msb_pkg::S_RD;
            end else begin
              cmd.i_inc  = 1'b1;
              state_next = msb_pkg::S_DD_TOP;
            end
          end
        end else begin
          cmd.rd_src = msb_pkg::RD_J;
          state_next = msb_pkg::S_CMP;
        end
      end
      msb_pkg::S_CMP: begin
        if (op_q == msb_pkg::OP_COUNT || (op_q == msb_pkg::OP_DEDUP && dd_cnt)) begin
          cmd.n_count = 1'b1;
          cmd.j_inc   = 1'b1;
          state_next  = msb_pkg::S_RD;
        end else if (sts.match) begin
          cmd.cnt_dec   = 1'b1;
          cmd.found_set = 1'b1;
          state_next    = msb_pkg::S_LASTRD;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = msb_pkg::S_RD;
        end
      end
      msb_pkg::S_LASTRD: begin
        cmd.rd_src = msb_pkg::RD_CNT;
        state_next = msb_pkg::S_LASTWR;
      end
      // Move the last entry into the freed slot.
      msb_pkg::S_LASTWR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = msb_pkg::WR_J_RD;
        case (op_q)
          msb_pkg::OP_ERASEA: state_next = msb_pkg::S_RD;
          msb_pkg::OP_DEDUP: begin
            if (sts.n_gt1) begin
              cmd.n_dec  = 1'b1;
              cmd.j_clr  = 1'b1;
              state_next = msb_pkg::S_RD;
            end else begin
              cmd.i_inc  = 1'b1;
              state_next = msb_pkg::S_DD_TOP;
            end
          end
          default: begin
            cmd.fin    = 1'b1;
            cmd.fin_ok = 1'b1;
            state_next = msb_pkg::S_IDLE;
          end
        endcase
      end
      // Selection sort, outer loop.
      msb_pkg::S_SORT_TOP: begin
        if (sts.sort_more) begin
          cmd.rd_src = msb_pkg::RD_I;
          state_next = msb_pkg::S_SORT_LI;
        end else begin
          cmd.fin    = 1'b1;
          cmd.fin_ok = 1'b1;
          state_next = msb_pkg::S_IDLE;
        end
      end
      msb_pkg::S_SORT_LI: begin
        cmd.sort_latch = 1'b1;
        state_next     = msb_pkg::S_SORT_RJ;
      end
      msb_pkg::S_SORT_RJ: begin
        if (sts.j_end) begin
          if (sts.swap) begin
            state_next = msb_pkg::S_SORT_W1;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = msb_pkg::S_SORT_TOP;
          end
        end else begin
          cmd.rd_src = msb_pkg::RD_J;
          state_next = msb_pkg::S_SORT_CJ;
        end
      end
      msb_pkg::S_SORT_CJ: begin
        cmd.sort_upd = 1'b1;
        cmd.j_inc    = 1'b1;
        state_next   = msb_pkg::S_SORT_RJ;
      end
      msb_pkg::S_SORT_W1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = msb_pkg::WR_MI_VI;
        state_next = msb_pkg::S_SORT_W2;
      end
      msb_pkg::S_SORT_W2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = msb_pkg::WR_I_MV;
        cmd.i_inc  = 1'b1;
        state_next = msb_pkg::S_SORT_TOP;
      end
      // Remove duplicates, outer walk.
      msb_pkg::S_DD_TOP: begin
        if (sts.i_lt) begin
          cmd.rd_src = msb_pkg::RD_I;
          state_next = msb_pkg::S_DD_KEY;
        end else begin
          cmd.fin    = 1'b1;
          cmd.fin_ok = 1'b1;
          state_next = msb_pkg::S_IDLE;
        end
      end
      msb_pkg::S_DD_KEY: begin
        cmd.key_rd  = 1'b1;
        cmd.j_clr   = 1'b1;
        dd_cnt_next = 1'b1;
        state_next  = msb_pkg::S_RD;
      end
      default: begin
        state_next = msb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[src/multiset_bag_table_core.sv]
// ----------------------------------------------------------------------------
// multiset_bag_table_core
// One operation at a time; busy is high from transfer until the result strobe,
// and the next transfer may come with the strobe. An unused op code is answered
// without raising busy. Each scanned entry is read through the registered read
// port of the entry RAM before it is compared.
// Synchronous reset empties the table; entry contents are not cleared.
// ----------------------------------------------------------------------------
module multiset_bag_table_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  input  logic [5:0]         index,
  output logic               done,
  output logic               ok,
  output logic [6:0]         match_count,
  output logic signed [31:0] read_value,
  output logic [6:0]         fill_level
);

  msb_pkg::cmd_t cmd;
  msb_pkg::sts_t sts;

  msb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  msb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .value       (value),
    .index       (index),
    .done        (done),
    .ok          (ok),
    .match_count (match_count),
    .read_value  (read_value),
    .fill_level  (fill_level)
  );

  // The result strobe appears only once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted transfer either starts a sequence or is answered at once.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transfer did not raise busy");

  // The fill level never passes the capacity.
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill_level <= 7'(msb_pkg::CAPACITY))
    else $error("fill level above capacity");

endmodule
